[design/mcce_pkg.sv]
// Shared types, constants and controller tables for the MIDI control change encoder.
package mcce_pkg;

    // Parameter store size and parameter index map
    localparam int NUM_PARAMS = 26;

    localparam logic [4:0] IDX_BANK          = 5'd0;
    localparam logic [4:0] IDX_SLOT          = 5'd1;
    localparam logic [4:0] IDX_EFFECT_FIRST  = 5'd2;
    localparam logic [4:0] IDX_EFFECT_LAST   = 5'd9;
    localparam logic [4:0] IDX_EXTRA_FIRST   = 5'd10;
    localparam logic [4:0] IDX_EXTRA_LAST    = 5'd13;
    localparam logic [4:0] IDX_LOOPER_FIRST  = 5'd14;
    localparam logic [4:0] IDX_LOOPER_LAST   = 5'd20;
    localparam logic [4:0] IDX_PEDAL_FIRST   = 5'd21;
    localparam logic [4:0] IDX_PEDAL_LAST    = 5'd24;
    localparam logic [4:0] IDX_MORPH         = 5'd25;

    // Input opcodes
    localparam logic OP_UPDATE = 1'b0;
    localparam logic OP_RESYNC = 1'b1;

    // Stored-value marker for a parameter never sent
    localparam logic [7:0] UNKNOWN_MARK = 8'h80;

    // Status nibbles
    localparam logic [3:0] STATUS_CC = 4'hB;
    localparam logic [3:0] STATUS_PC = 4'hC;

    // Controller numbers and fixed values
    localparam logic [6:0] CC_BANK_SEL      = 7'd32;
    localparam logic [6:0] CC_NRPN_MSB      = 7'd99;
    localparam logic [6:0] CC_NRPN_LSB      = 7'd98;
    localparam logic [6:0] CC_DATA_MSB      = 7'd6;
    localparam logic [6:0] CC_DATA_LSB      = 7'd38;
    localparam logic [6:0] NRPN_PAGE        = 7'd125;
    localparam logic [6:0] NRPN_LOOPER_BASE = 7'd88;
    localparam logic [6:0] CC_EXTRA_BASE    = 7'd75;
    localparam logic [6:0] CC_SLOT_BASE     = 7'd49;

    // Bank arithmetic limits
    localparam logic [6:0] BANK_MAX = 7'd124;
    localparam logic [6:0] PROG_MAX = 7'd127;

    // Slots and sequence time offsets
    localparam logic [2:0] NUM_SLOTS         = 3'd5;
    localparam logic [2:0] BANK_SLOT_OFFSET  = 3'd2;
    localparam logic [2:0] MORPH_SLOT_OFFSET = 3'd4;

    // Command passed from the front end to the message sequencer
    typedef enum logic [1:0] {
        CMD_CC,
        CMD_NRPN,
        CMD_BANK,
        CMD_SLOT
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind  kind;
        logic [6:0] ctrl;   // controller number, or NRPN low number
        logic [6:0] value;  // controller value, or bank select value
        logic [6:0] prog;   // program number for a bank change
        logic [2:0] slot;   // slot for the press/release sequence
        logic [2:0] toff;   // time offset of the slot sequence
    } t_cmd;

    // Effect switch controller numbers
    function automatic logic [6:0] effect_cc(input logic [2:0] k);
        logic [6:0] cc;
        case (k)
            3'd0:    cc = 7'd17;
            3'd1:    cc = 7'd18;
            3'd2:    cc = 7'd19;
            3'd3:    cc = 7'd20;
            3'd4:    cc = 7'd22;
            3'd5:    cc = 7'd24;
            3'd6:    cc = 7'd27;
            default: cc = 7'd29;
        endcase
        return cc;
    endfunction

    // Pedal controller numbers: morph, expression, wah, gain
    function automatic logic [6:0] pedal_cc(input logic [1:0] k);
        logic [6:0] cc;
        case (k)
            2'd0:    cc = 7'd11;
            2'd1:    cc = 7'd1;
            2'd2:    cc = 7'd7;
            default: cc = 7'd72;
        endcase
        return cc;
    endfunction

endpackage

[design/mcce_cfg_if.sv]
// Configuration write channel carrying the MIDI channel register.
interface mcce_cfg_if;
    logic       valid;
    logic       ready;
    logic [4:0] midi_channel;

    modport source (output valid, output midi_channel, input ready);
    modport sink   (input valid, input midi_channel, output ready);
endinterface

[design/mcce_in_if.sv]
// Input channel carrying parameter updates and resync commands.
interface mcce_in_if;
    logic       valid;
    logic       ready;
    logic       opcode;
    logic [4:0] param_index;
    logic [6:0] param_value;

    modport source (output valid, output opcode, output param_index, output param_value,
                    input ready);
    modport sink   (input valid, input opcode, input param_index, input param_value,
                    output ready);
endinterface

[design/mcce_out_if.sv]
// Output channel carrying encoded MIDI messages.
interface mcce_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] status_byte;
    logic [6:0] data_first;
    logic [6:0] data_second;
    logic [2:0] time_offset;
    logic       last_message;

    modport source (output valid, output status_byte, output data_first, output data_second,
                    output time_offset, output last_message, input ready);
    modport sink   (input valid, input status_byte, input data_first, input data_second,
                    input time_offset, input last_message, output ready);
endinterface

[design/midi_control_change_encoder_core.sv]
// The first message of an item is offered after its command passes the queue and output register.
// Throughput: one message per cycle from the sequencer while the output is taken; an item
// producing k messages (0 to 8) holds the sequencer until its last message is loaded.
// Items that produce no message are not queued; the command queue lets input continue.
// Reset: MIDI channel 1, all sent values unknown, slot 1 selected, queue empty.
module midi_control_change_encoder_core
    import mcce_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    mcce_cfg_if.sink   i_cfg,
    mcce_in_if.sink    i_in,
    mcce_out_if.source o_out
);

    logic [4:0] r_midi_channel;
    logic       push;
    logic       pop;
    logic       queue_full;
    logic       queue_empty;
    t_cmd       cmd;
    t_cmd       head;

    // Channel register takes every write transfer
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_midi_channel <= 5'd1;
        end else if (i_cfg.valid && i_cfg.ready) begin
            r_midi_channel <= i_cfg.midi_channel;
        end
    end

    mcce_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (i_in),
        .i_queue_full (queue_full),
        .o_push       (push),
        .o_cmd        (cmd)
    );

    mcce_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (cmd),
        .i_pop   (pop),
        .o_full  (queue_full),
        .o_empty (queue_empty),
        .o_head  (head)
    );

    mcce_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_midi_channel (r_midi_channel),
        .i_head         (head),
        .i_empty        (queue_empty),
        .o_pop          (pop),
        .o_out          (o_out)
    );

endmodule

[design/mcce_front.sv]
// Front end: accepts updates, compares against the sent values and issues commands.
module mcce_front
    import mcce_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    mcce_in_if.sink i_in,
    input  logic    i_queue_full,
    output logic    o_push,
    output t_cmd    o_cmd
);

    logic [7:0] r_sent [NUM_PARAMS];
    logic [7:0] n_sent [NUM_PARAMS];
    logic [2:0] r_cur_slot;
    logic [2:0] n_cur_slot;

    logic       accept;
    logic [4:0] idx;
    logic [6:0] v;
    logic [7:0] v_ext;
    logic       idx_ok;
    logic [7:0] stored;
    logic       on;
    logic       slot_ok;
    logic [6:0] bank_v;
    logic [6:0] bank_m1;
    logic [9:0] rig_off;
    logic [7:0] prog_raw;
    logic [6:0] bank_sel;
    logic [6:0] bank_prog;

    // Take a transfer whenever the queue has room
    assign i_in.ready = !i_queue_full;
    assign accept     = i_in.valid && i_in.ready;

    assign idx     = i_in.param_index;
    assign v       = i_in.param_value;
    assign v_ext   = {1'b0, v};
    assign idx_ok  = (idx <= IDX_MORPH);
    assign stored  = idx_ok ? r_sent[idx] : UNKNOWN_MARK;
    assign on      = |v;
    assign slot_ok = (v >= 7'd1) && (v <= {4'b0, NUM_SLOTS});

    // Bank arithmetic: rig offset (b-1)*5, bank select is its upper part
    assign bank_v    = (v > BANK_MAX) ? BANK_MAX : v;
    assign bank_m1   = bank_v - 7'd1;
    assign rig_off   = {3'b0, bank_m1} * 10'd5;
    assign prog_raw  = {1'b0, rig_off[6:0]} + 8'd1;
    assign bank_sel  = (bank_v == 7'd0) ? 7'd0 : {4'b0, rig_off[9:7]};
    assign bank_prog = (bank_v == 7'd0) ? 7'd0 :
                       (prog_raw[7] ? PROG_MAX : prog_raw[6:0]);

    // Classify the item and update the sent values
    always_comb begin
        n_sent     = r_sent;
        n_cur_slot = r_cur_slot;
        o_push     = 1'b0;
        o_cmd      = '0;
        o_cmd.kind = CMD_CC;
        if (accept) begin
            if (i_in.opcode == OP_RESYNC) begin
                for (int k = 0; k < NUM_PARAMS; k++) begin
                    n_sent[k] = UNKNOWN_MARK;
                end
            end else if (idx_ok) begin
                if (idx == IDX_BANK) begin
                    if ({1'b0, bank_v} != stored) begin
                        o_push           = 1'b1;
                        o_cmd.kind       = CMD_BANK;
                        o_cmd.value      = bank_sel;
                        o_cmd.prog       = bank_prog;
                        o_cmd.slot       = r_cur_slot;
                        o_cmd.toff       = BANK_SLOT_OFFSET;
                        n_sent[IDX_BANK] = {1'b0, bank_v};
                        n_sent[IDX_SLOT] = {5'b0, r_cur_slot};
                    end
                end else if (idx == IDX_SLOT) begin
                    n_cur_slot = slot_ok ? v[2:0] : 3'd0;
                    if (v_ext != stored) begin
                        o_push           = 1'b1;
                        o_cmd.kind       = CMD_SLOT;
                        o_cmd.slot       = n_cur_slot;
                        o_cmd.toff       = 3'd0;
                        n_sent[IDX_SLOT] = v_ext;
                    end
                end else if (v_ext != stored) begin
                    n_sent[idx] = v_ext;
                    if (idx <= IDX_EFFECT_LAST) begin
                        o_push      = 1'b1;
                        o_cmd.kind  = CMD_CC;
                        o_cmd.ctrl  = effect_cc(3'(idx - IDX_EFFECT_FIRST));
                        o_cmd.value = {6'b0, on};
                    end else if (idx <= IDX_EXTRA_LAST) begin
                        o_push      = 1'b1;
                        o_cmd.kind  = CMD_CC;
                        o_cmd.ctrl  = CC_EXTRA_BASE + {5'b0, 2'(idx - IDX_EXTRA_FIRST)};
                        o_cmd.value = {6'b0, on};
                    end else if (idx <= IDX_LOOPER_LAST) begin
                        o_push      = 1'b1;
                        o_cmd.kind  = CMD_NRPN;
                        o_cmd.ctrl  = NRPN_LOOPER_BASE + {4'b0, 3'(idx - IDX_LOOPER_FIRST)};
                        o_cmd.value = {6'b0, on};
                    end else if (idx <= IDX_PEDAL_LAST) begin
                        o_push      = 1'b1;
                        o_cmd.kind  = CMD_CC;
                        o_cmd.ctrl  = pedal_cc(2'(idx - IDX_PEDAL_FIRST));
                        o_cmd.value = v;
                    end else if (!stored[7]) begin
                        // Morph toggle: first value is only remembered
                        o_push     = 1'b1;
                        o_cmd.kind = CMD_SLOT;
                        o_cmd.slot = r_cur_slot;
                        o_cmd.toff = MORPH_SLOT_OFFSET;
                    end
                end
            end
        end
    end

    // Hold sent values and the selected slot
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_PARAMS; k++) begin
                r_sent[k] <= UNKNOWN_MARK;
            end
            r_cur_slot <= 3'd1;
        end else begin
            r_sent     <= n_sent;
            r_cur_slot <= n_cur_slot;
        end
    end

    a_slot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cur_slot <= NUM_SLOTS)
        else $error("selected slot out of range");

    a_resync_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_in.opcode == OP_RESYNC) |-> !o_push)
        else $error("resync issued a command");

endmodule

[design/mcce_queue.sv]
// Short command queue between the front end and the message sequencer.
module mcce_queue
    import mcce_pkg::*;
#(
    parameter int DEPTH = 2
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    input  logic i_pop,
    output logic o_full,
    output logic o_empty,
    output t_cmd o_head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_cmd             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];

    // Store pushed commands
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("command queue overflow");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && o_empty))
        else $error("command queue underflow");

endmodule

[design/mcce_back.sv]
// Message sequencer: expands queued commands into MIDI messages, one per cycle while taken.
module mcce_back
    import mcce_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic [4:0]    i_midi_channel,
    input  t_cmd          i_head,
    input  logic          i_empty,
    output logic          o_pop,
    mcce_out_if.source    o_out
);

    logic [2:0] r_step;
    logic       r_valid;
    logic [7:0] r_status;
    logic [6:0] r_data_first;
    logic [6:0] r_data_second;
    logic [2:0] r_time_offset;
    logic       r_last;

    logic       advance;
    logic       fire;
    logic [3:0] channel;
    logic       slot_valid;
    logic [2:0] nrel;
    logic [2:0] slot_step;
    logic [2:0] rel_slot;
    logic       slot_step_ok;

    logic       m_pc;
    logic [6:0] m_d1;
    logic [6:0] m_d2;
    logic [2:0] m_toff;
    logic       m_last;

    // Output register moves on when empty or taken
    assign advance = !r_valid || o_out.ready;
    assign fire    = advance && !i_empty;
    assign o_pop   = fire && m_last;
    assign channel = 4'(i_midi_channel - 5'd1);

    // Slot sequence position: releases of the other slots, then press and release; all released if invalid
    assign slot_valid   = (i_head.slot >= 3'd1) && (i_head.slot <= NUM_SLOTS);
    assign nrel         = slot_valid ? NUM_SLOTS - 3'd1 : NUM_SLOTS;
    assign slot_step    = (i_head.kind == CMD_BANK) ? r_step - BANK_SLOT_OFFSET : r_step;
    assign slot_step_ok = slot_valid && (slot_step + 3'd1 >= i_head.slot);
    assign rel_slot     = slot_step_ok ? slot_step + 3'd2 : slot_step + 3'd1;

    // Build the message for the current step
    always_comb begin
        m_pc   = 1'b0;
        m_d1   = '0;
        m_d2   = '0;
        m_toff = '0;
        m_last = 1'b0;
        unique case (i_head.kind)
            CMD_CC: begin
                m_d1   = i_head.ctrl;
                m_d2   = i_head.value;
                m_last = 1'b1;
            end
            CMD_NRPN: begin
                unique case (r_step)
                    3'd0: begin
                        m_d1 = CC_NRPN_MSB;
                        m_d2 = NRPN_PAGE;
                    end
                    3'd1: begin
                        m_d1 = CC_NRPN_LSB;
                        m_d2 = i_head.ctrl;
                    end
                    3'd2: begin
                        m_d1 = CC_DATA_MSB;
                        m_d2 = 7'd0;
                    end
                    default: begin
                        m_d1   = CC_DATA_LSB;
                        m_d2   = i_head.value;
                        m_last = 1'b1;
                    end
                endcase
            end
            CMD_BANK, CMD_SLOT: begin
                if (i_head.kind == CMD_BANK && r_step == 3'd0) begin
                    m_d1 = CC_BANK_SEL;
                    m_d2 = i_head.value;
                end else if (i_head.kind == CMD_BANK && r_step == 3'd1) begin
                    m_pc   = 1'b1;
                    m_d1   = i_head.prog;
                    m_toff = 3'd1;
                end else if (slot_step < nrel) begin
                    m_d1   = CC_SLOT_BASE + {4'b0, rel_slot};
                    m_toff = i_head.toff;
                    m_last = !slot_valid && (slot_step == nrel - 3'd1);
                end else if (slot_step == nrel) begin
                    m_d1   = CC_SLOT_BASE + {4'b0, i_head.slot};
                    m_d2   = 7'd1;
                    m_toff = i_head.toff;
                end else begin
                    m_d1   = CC_SLOT_BASE + {4'b0, i_head.slot};
                    m_toff = i_head.toff + 3'd1;
                    m_last = 1'b1;
                end
            end
            default: begin
                m_last = 1'b1;
            end
        endcase
    end

    // Advance the step counter and drop the command after its last message
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step  <= '0;
            r_valid <= 1'b0;
        end else begin
            if (advance) begin
                r_valid <= !i_empty;
            end
            if (fire) begin
                r_step <= m_last ? 3'd0 : r_step + 3'd1;
            end
        end
    end

    // Load the output register
    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_status      <= {m_pc ? STATUS_PC : STATUS_CC, channel};
            r_data_first  <= m_d1;
            r_data_second <= m_d2;
            r_time_offset <= m_toff;
            r_last        <= m_last;
        end
    end

    assign o_out.valid        = r_valid;
    assign o_out.status_byte  = r_status;
    assign o_out.data_first   = r_data_first;
    assign o_out.data_second  = r_data_second;
    assign o_out.time_offset  = r_time_offset;
    assign o_out.last_message = r_last;

    a_cc_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!i_empty && i_head.kind == CMD_CC) |-> (r_step == 3'd0))
        else $error("control change command past its only message");

    a_nrpn_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!i_empty && i_head.kind == CMD_NRPN) |-> (r_step <= 3'd3))
        else $error("NRPN command past its fourth message");

endmodule
